// ===== rtl/scancode_to_ascii_fifo_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SCANCODE_TO_ASCII_FIFO_MACROS_SVH
`define SCANCODE_TO_ASCII_FIFO_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define S2A_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("s2a check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define S2A_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("s2a check failed");

`endif

// ===== rtl/s2a_pkg.sv =====
// Package: types, constants and the set-1 keymap for the scancode FIFO.
`timescale 1ns / 1ps
package s2a_pkg;

	localparam int CAPACITY    = 16;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SCAN_W      = 8;
	localparam int CHAR_W      = 7;
	localparam int RELEASE_BIT = 7;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [SCAN_W-1:0] scan_t;

	typedef enum logic {
		REQ_SCAN = 1'b0,
		REQ_POP  = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic  en;
		logic  push;
		logic  pop;
		char_t wdata;
	} fifo_cmd_t;

	typedef struct packed {
		logic  char_valid;
		char_t char_out;
		logic  stored;
		logic  dropped;
		logic  is_empty;
		logic  is_full;
	} fifo_rsp_t;

	function automatic idx_t ring_next(idx_t i);
		if (i == idx_t'(CAPACITY - 1)) begin
			return '0;
		end
		return i + idx_t'(1);
	endfunction

	// Unshifted US layout; zero means no character.
	function automatic char_t set1_lookup(logic [6:0] code);
		char_t c;
		case (code)
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h29: c = 7'h60;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h39: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/s2a_req_if.sv =====
// Request channel: scancode byte or pop request.
`timescale 1ns / 1ps
interface s2a_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] scan_byte;

	modport source (output valid, output req_type, output scan_byte, input ready);
	modport sink   (input valid, input req_type, input scan_byte, output ready);
endinterface

// ===== rtl/s2a_rsp_if.sv =====
// Result channel: popped character and FIFO status.
`timescale 1ns / 1ps
interface s2a_rsp_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [6:0] char_out;
	logic       stored;
	logic       dropped;
	logic       is_empty;
	logic       is_full;

	modport source (output valid, output char_valid, output char_out, output stored,
		output dropped, output is_empty, output is_full, input ready);
	modport sink   (input valid, input char_valid, input char_out, input stored,
		input dropped, input is_empty, input is_full, output ready);
endinterface

// ===== rtl/s2a_char_fifo.sv =====
// Character ring FIFO with one slot kept free; push/pop decision and status.
`timescale 1ns / 1ps
module s2a_char_fifo
	import s2a_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  fifo_cmd_t cmd,
	output fifo_rsp_t rsp
);

	char_t store_q [CAPACITY];
	idx_t  wr_idx_q;
	idx_t  rd_idx_q;

	logic  empty;
	logic  full;
	logic  do_push;
	logic  do_pop;
	idx_t  wr_next;
	idx_t  rd_next;

	always_comb begin
		empty   = (wr_idx_q == rd_idx_q);
		full    = (ring_next(wr_idx_q) == rd_idx_q);
		do_push = cmd.push && !full;
		do_pop  = cmd.pop && !empty;
		wr_next = do_push ? ring_next(wr_idx_q) : wr_idx_q;
		rd_next = do_pop ? ring_next(rd_idx_q) : rd_idx_q;

		rsp.char_valid = do_pop;
		rsp.char_out   = do_pop ? store_q[rd_idx_q] : '0;
		rsp.stored     = do_push;
		rsp.dropped    = cmd.push && full;
		rsp.is_empty   = (wr_next == rd_next);
		rsp.is_full    = (ring_next(wr_next) == rd_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else if (cmd.en) begin
			wr_idx_q <= wr_next;
			rd_idx_q <= rd_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en && do_push) begin
			store_q[wr_idx_q] <= cmd.wdata;
		end
	end

endmodule

// ===== rtl/scancode_to_ascii_fifo.sv =====
// An accepted request does its keymap lookup and FIFO access in the input stage;
// the outcome is loaded into the result register, which offers the result beat.
// Throughput: one request per cycle unless a result beat is stalled.
// The input stage advances whenever the result register is empty or being drained.
// Reset: indices cleared, FIFO empty, both stages invalid; character storage
// is not cleared and holds no meaning until written.
`timescale 1ns / 1ps
module scancode_to_ascii_fifo
	import s2a_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	s2a_req_if.sink      req,
	s2a_rsp_if.source    rsp
);

	logic      valid_s1;
	logic      req_type_s1;
	scan_t     scan_s1;

	logic      valid_s2;
	fifo_rsp_t res_s2;

	logic      advance;
	char_t     mapped;
	fifo_cmd_t cmd;
	fifo_rsp_t res;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			scan_s1     <= req.scan_byte;
		end
	end

	always_comb begin
		mapped    = set1_lookup(scan_s1[6:0]);
		cmd.en    = valid_s1 && advance;
		cmd.pop   = valid_s1 && (req_type_s1 == REQ_POP);
		// release codes and unmapped make codes never reach the FIFO
		cmd.push  = valid_s1 && (req_type_s1 == REQ_SCAN) && !scan_s1[RELEASE_BIT]
			&& (mapped != '0);
		cmd.wdata = mapped;
	end

	s2a_char_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.char_valid = res_s2.char_valid;
	assign rsp.char_out   = res_s2.char_out;
	assign rsp.stored     = res_s2.stored;
	assign rsp.dropped    = res_s2.dropped;
	assign rsp.is_empty   = res_s2.is_empty;
	assign rsp.is_full    = res_s2.is_full;

endmodule

// ===== rtl/s2a_checker.sv =====
// Port-level checks for the scancode FIFO, bound to the top level.
`timescale 1ns / 1ps
`include "scancode_to_ascii_fifo_macros.svh"
module s2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       char_valid,
	input logic [6:0] char_out,
	input logic       stored,
	input logic       dropped,
	input logic       is_empty,
	input logic       is_full
);

	// a stalled result beat stays up
	`S2A_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// a pop never reports a push outcome, and a dropped char means the FIFO was full
	`S2A_ASSERT_NOW(a_kind_excl, out_valid && char_valid, !stored && !dropped)
	`S2A_ASSERT_NOW(a_drop_full, out_valid && dropped, is_full && !stored)
	// a stored char leaves the FIFO non-empty, and empty and full never coincide
	`S2A_ASSERT_NOW(a_flags, out_valid && (stored || is_full), !is_empty)
	`S2A_ASSERT_NOW(a_char_zero, out_valid && !char_valid, char_out == 7'd0)

endmodule

bind scancode_to_ascii_fifo s2a_checker u_s2a_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.char_valid (rsp.char_valid),
	.char_out   (rsp.char_out),
	.stored     (rsp.stored),
	.dropped    (rsp.dropped),
	.is_empty   (rsp.is_empty),
	.is_full    (rsp.is_full)
);

// ===== tb/tb.sv =====
// Testbench for scancode_to_ascii_fifo: keymap and ring FIFO checked beat by beat.
`timescale 1ns / 1ps
module tb;
	import s2a_pkg::*;

	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE_EDGES = 8;

	logic clk = 1'b0;
	logic arst_n;

	s2a_req_if req_bus ();
	s2a_rsp_if rsp_bus ();

	scancode_to_ascii_fifo u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Set-1 make codes 0x00..0x3F, unshifted US layout; zero = no character.
	char_t make_ascii [64] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	// Shadow of the character ring
	char_t     ring_chars [CAPACITY];
	idx_t      wr_slot = '0;
	idx_t      rd_slot = '0;
	fifo_rsp_t expected_rsp_q [$];

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int error_count   = 0;
	bit hold_request  = 1'b0;
	bit hold_on       = 1'b0;

	function automatic char_t lookup_make(logic [6:0] code);
		if (code[6]) begin
			return '0;
		end
		return make_ascii[code[5:0]];
	endfunction

	function automatic idx_t advance_slot(idx_t i);
		return idx_t'((int'(i) + 1) % CAPACITY);
	endfunction

	function automatic fifo_rsp_t predict_key(req_kind_t kind, scan_t sc);
		fifo_rsp_t r;
		char_t     c;
		r = '0;
		if (kind == REQ_POP) begin
			if (wr_slot != rd_slot) begin
				r.char_valid = 1'b1;
				r.char_out   = ring_chars[rd_slot];
				rd_slot      = advance_slot(rd_slot);
			end
		end else if (!sc[RELEASE_BIT]) begin
			c = lookup_make(sc[6:0]);
			if (c != '0) begin
				if (advance_slot(wr_slot) == rd_slot) begin
					r.dropped = 1'b1;
				end else begin
					ring_chars[wr_slot] = c;
					wr_slot             = advance_slot(wr_slot);
					r.stored            = 1'b1;
				end
			end
		end
		r.is_empty = (wr_slot == rd_slot);
		r.is_full  = (advance_slot(wr_slot) == rd_slot);
		return r;
	endfunction

	function automatic scan_t random_make_code();
		scan_t c;
		do begin
			c = scan_t'($urandom_range(8'h39, 8'h02));
		end while (lookup_make(c[6:0]) == '0);
		return c;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want) begin
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	// Sends one request beat and records its predicted result on acceptance.
	task automatic send_req(req_kind_t kind, scan_t sc);
		bit rdy;
		while ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.req_type  <= kind;
		req_bus.scan_byte <= sc;
		do begin
			@(negedge clk);
			rdy = req_bus.ready;
			@(posedge clk);
		end while (!rdy);
		expected_rsp_q.push_back(predict_key(kind, sc));
	endtask

	// Result side: sample mid-cycle, score after the edge, then pick ready.
	initial begin
		bit        fire;
		fifo_rsp_t got;
		fifo_rsp_t want;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			fire           = arst_n && rsp_bus.valid && rsp_bus.ready;
			got.char_valid = rsp_bus.char_valid;
			got.char_out   = rsp_bus.char_out;
			got.stored     = rsp_bus.stored;
			got.dropped    = rsp_bus.dropped;
			got.is_empty   = rsp_bus.is_empty;
			got.is_full    = rsp_bus.is_full;
			@(posedge clk);
			if (fire) begin
				if (expected_rsp_q.size() == 0) begin
					report_error("result beat with nothing expected");
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("char_valid", int'(got.char_valid), int'(want.char_valid));
					check_field("char_out", int'(got.char_out), int'(want.char_out));
					check_field("stored", int'(got.stored), int'(want.stored));
					check_field("dropped", int'(got.dropped), int'(want.dropped));
					check_field("is_empty", int'(got.is_empty), int'(want.is_empty));
					check_field("is_full", int'(got.is_full), int'(want.is_full));
				end
			end
			rsp_bus.ready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Long receiver hold-off, counted in cycles
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_on      = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on = 1'b0;
			end
		end
	end

	task automatic test_directed();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		send_req(REQ_POP, 8'hFF);   // pop on empty, scan byte ignored
		send_req(REQ_SCAN, 8'h00);  // unmapped
		send_req(REQ_SCAN, 8'h7F);  // highest make code, unmapped
		send_req(REQ_SCAN, 8'h80);  // releases
		send_req(REQ_SCAN, 8'hFF);
		send_req(REQ_SCAN, 8'h1D);  // hole in the table
		// 15 keys fill the ring, the 16th is dropped
		for (int i = 0; i < CAPACITY - 1; i++) begin
			send_req(REQ_SCAN, scan_t'(8'h02 + i));
		end
		send_req(REQ_SCAN, 8'h39);
		send_req(REQ_POP, 8'h00);
		send_req(REQ_POP, 8'h55);
		send_req(REQ_POP, 8'hAA);
	endtask

	task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
		int    done;
		int    push_pct;
		int    roll;
		scan_t code;
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		done          = 0;
		push_pct      = 50;
		while (done < n_items) begin
			// shift the push/pop mix now and then so the ring swings full and empty
			if ($urandom_range(39) == 0) begin
				push_pct = $urandom_range(70, 25);
			end
			roll = $urandom_range(99);
			if (roll < 15) begin
				code = scan_t'($urandom_range(255));
				send_req($urandom_range(1) ? REQ_POP : REQ_SCAN, code);
				done++;
			end else if (roll < 15 + (85 * push_pct) / 100) begin
				code = random_make_code();
				send_req(REQ_SCAN, code);
				done++;
				if ($urandom_range(1)) begin
					send_req(REQ_SCAN, code | 8'h80);
					done++;
				end
			end else begin
				send_req(REQ_POP, scan_t'($urandom_range(255)));
				done++;
			end
		end
	endtask

	task automatic test_backpressure();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_request  = 1'b1;
		for (int i = 0; i < 40; i++) begin
			if (i % 3 == 2) begin
				send_req(REQ_POP, scan_t'($urandom_range(255)));
			end else begin
				send_req(REQ_SCAN, random_make_code());
			end
		end
	endtask

	task automatic finish_run();
		int waited;
		req_bus.valid <= 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		waited        = 0;
		while (expected_rsp_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_EDGES) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			report_error($sformatf("%0d results never arrived", expected_rsp_q.size()));
		end
		if (error_count == 0) begin
			$display("PASS scancode_to_ascii_fifo");
		end else begin
			$display("FAIL scancode_to_ascii_fifo");
		end
		$finish;
	endtask

	initial begin
		arst_n            = 1'b0;
		req_bus.valid     = 1'b0;
		req_bus.req_type  = REQ_SCAN;
		req_bus.scan_byte = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(0, 0, 210);
		test_random_traffic(69, 0, 210);
		test_random_traffic(0, 69, 210);
		test_random_traffic(13, 13, 210);
		test_backpressure();
		finish_run();
	end

	initial begin
		#2_000_000;
		$display("FAIL scancode_to_ascii_fifo");
		$finish;
	end

endmodule
